// File: hdl/vrbt_pkg.sv
// Package for the variable register binding table.
// Pool size, id width, derived widths and request codes; no dependencies.
package vrbt_pkg;

    localparam int POOL_SIZE = 8;   // at least 3, at most 32
    localparam int ID_BITS   = 16;  // 4 to 32
    localparam int IDX_BITS  = $clog2(POOL_SIZE);

    localparam logic [5:0] BASE_RESET = 6'd8;

    typedef logic [ID_BITS-1:0]  id_t;
    typedef logic [IDX_BITS-1:0] idx_t;

    localparam logic OP_BIND = 1'b0;
    localparam logic OP_ANON = 1'b1;

endpackage

// File: hdl/variable_register_binding_table_top.sv
// Variable register binding table: associative id lookup, lowest-free allocation
// and spilling with a two-entry victim history. Uses vrbt_pkg.
//
// Path: a request is held in the request register, then its result in the result register that drives done.
// Throughput: one request per cycle; busy never rises, since each request's table
// update lands at the same edge that registers the next request.
// Reset (rst_n low, asynchronous): table empty, victim history invalid, base 8.
// The receiver cannot stall: done is high for exactly one cycle per result.
module variable_register_binding_table_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [15:0] var_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    output logic        done,
    output logic [6:0]  reg_number,
    output logic        is_new,
    output logic        spilled,
    output logic [15:0] spill_var_id
);

    localparam int N = vrbt_pkg::POOL_SIZE;

    // configuration
    logic [5:0] base_reg;

    // request register
    logic          in_valid_reg;
    logic          op_reg;
    vrbt_pkg::id_t vid_reg;

    // table state
    logic [N-1:0]  in_use_reg, in_use_next;
    logic [N-1:0]  bound_reg,  bound_next;
    vrbt_pkg::id_t owner_reg  [N];
    vrbt_pkg::id_t owner_next [N];
    logic           va_valid_reg, va_valid_next;
    logic           vb_valid_reg, vb_valid_next;
    vrbt_pkg::idx_t va_idx_reg,   va_idx_next;
    vrbt_pkg::idx_t vb_idx_reg,   vb_idx_next;

    // result register
    logic          done_reg;
    logic [6:0]    reg_number_reg;
    logic          is_new_reg;
    logic          spilled_reg;
    vrbt_pkg::id_t spill_id_reg;

    // lookup and allocation
    logic           anon;
    logic           hit, free_found, victim_found, do_spill;
    vrbt_pkg::idx_t hit_idx, free_idx, victim_idx, slot;
    vrbt_pkg::id_t  spill_id;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign anon = (op_reg == vrbt_pkg::OP_ANON);

    always_comb
    begin
        hit          = 1'b0;
        hit_idx      = '0;
        free_found   = 1'b0;
        free_idx     = '0;
        victim_found = 1'b0;
        victim_idx   = '0;
        for (int i = 0; i < N; i++)
        begin
            if (!hit && bound_reg[i] && owner_reg[i] == vid_reg)
            begin
                hit     = 1'b1;
                hit_idx = vrbt_pkg::idx_t'(i);
            end
            if (!free_found && !in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = vrbt_pkg::idx_t'(i);
            end
            if (!victim_found
                && !(va_valid_reg && va_idx_reg == vrbt_pkg::idx_t'(i))
                && !(vb_valid_reg && vb_idx_reg == vrbt_pkg::idx_t'(i)))
            begin
                victim_found = 1'b1;
                victim_idx   = vrbt_pkg::idx_t'(i);
            end
        end
        hit      = hit && !anon;
        do_spill = !hit && !free_found;
        slot     = hit ? hit_idx : (free_found ? free_idx : victim_idx);
        spill_id = owner_reg[victim_idx];
    end

    always_comb
    begin
        in_use_next   = in_use_reg;
        bound_next    = bound_reg;
        owner_next    = owner_reg;
        va_valid_next = va_valid_reg;
        vb_valid_next = vb_valid_reg;
        va_idx_next   = va_idx_reg;
        vb_idx_next   = vb_idx_reg;
        if (in_valid_reg && !hit)
        begin
            if (free_found)
            begin
                in_use_next[slot] = 1'b1;
            end
            else
            begin
                if (!va_valid_reg)
                begin
                    va_valid_next = 1'b1;
                    va_idx_next   = victim_idx;
                end
                else if (!vb_valid_reg)
                begin
                    vb_valid_next = 1'b1;
                    vb_idx_next   = victim_idx;
                end
                else
                begin
                    va_idx_next = vb_idx_reg;
                    vb_idx_next = victim_idx;
                end
                // a stale victim id can unbind another entry as well
                for (int i = 0; i < N; i++)
                begin
                    if (owner_reg[i] == spill_id)
                    begin
                        bound_next[i] = 1'b0;
                    end
                end
            end
            if (!anon)
            begin
                owner_next[slot] = vid_reg;
                bound_next[slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= vrbt_pkg::BASE_RESET;
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            in_use_reg   <= '0;
            bound_reg    <= '0;
            va_valid_reg <= 1'b0;
            vb_valid_reg <= 1'b0;
            va_idx_reg   <= '0;
            vb_idx_reg   <= '0;
            for (int i = 0; i < N; i++)
            begin
                owner_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
            in_use_reg   <= in_use_next;
            bound_reg    <= bound_next;
            owner_reg    <= owner_next;
            va_valid_reg <= va_valid_next;
            vb_valid_reg <= vb_valid_next;
            va_idx_reg   <= va_idx_next;
            vb_idx_reg   <= vb_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= operation;
            vid_reg <= vrbt_pkg::id_t'(var_id);
        end
        if (in_valid_reg)
        begin
            reg_number_reg <= 7'({1'b0, base_reg} + 7'(slot));
            is_new_reg     <= !hit;
            spilled_reg    <= do_spill;
            spill_id_reg   <= do_spill ? spill_id : '0;
        end
    end

    assign done         = done_reg;
    assign reg_number   = reg_number_reg;
    assign is_new       = is_new_reg;
    assign spilled      = spilled_reg;
    assign spill_var_id = 16'(spill_id_reg);

    // checks
    a_transfer_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("request did not give a result two cycles later");

    a_spill_is_new: assert property (@(posedge clk) disable iff (!rst_n)
        done && spilled |-> is_new)
        else $error("spill reported on a reused binding");

    a_history_order: assert property (@(posedge clk) disable iff (!rst_n)
        vb_valid_reg |-> va_valid_reg)
        else $error("second victim recorded before the first");

    a_history_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        va_valid_reg && vb_valid_reg |-> va_idx_reg != vb_idx_reg)
        else $error("victim history holds the same entry twice");

endmodule
